// ===== hdl/ors_pkg.sv =====
// Shared constants and codes for the owned range set.
`default_nettype none
package ors_pkg;
    localparam int MAX_RANGES  = 32;
    localparam int INDEX_LIMIT = 4096;
    localparam int IDX_W  = $clog2(INDEX_LIMIT);
    localparam int END_W  = IDX_W + 1;
    localparam int CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int PTR_W  = $clog2(MAX_RANGES);
    localparam int N_W    = $clog2(MAX_RANGES + 3);
    localparam int ENTRY_W = IDX_W + END_W;

    localparam logic [1:0] REQ_MARK   = 2'd0;
    localparam logic [1:0] REQ_UNMARK = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/ors_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface ors_req_if;
    import ors_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [IDX_W-1:0] start_index;
    logic [END_W-1:0] span_count;
    modport source (output valid, req_type, start_index, span_count, input ready);
    modport sink   (input valid, req_type, start_index, span_count, output ready);
endinterface

interface ors_rsp_if;
    import ors_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] range_begin;
    logic [END_W-1:0] range_end;
    logic             range_valid;
    logic [CNT_W-1:0] range_total;
    logic             last;
    modport source (output valid, status, range_begin, range_end, range_valid,
                    range_total, last, input ready);
    modport sink   (input valid, status, range_begin, range_end, range_valid,
                    range_total, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/ors_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ors_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/owned_range_set_top.sv =====
// Top level of the owned range set: sequencer over a double-banked range table.
`default_nettype none
// Keeps up to MAX_RANGES sorted disjoint ranges [begin,end) in one RAM split
// into two banks. A mark or unmark reads every stored range of the active bank
// in turn and writes the new table into the other bank, then swaps banks only
// if the result fits, so a table-full request leaves the set untouched. Each
// stored range is read and then evaluated, with an extra write step where a
// range is inserted or split; clear and ignored requests go straight to the
// response. A list gives one result per stored range (one empty result for an
// empty table), each read and then output once the response side is free.
// Requests are taken only between operations; a finished result may wait in the
// output register while the next request is taken. No clearing pass after reset.
module owned_range_set_top (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [ors_pkg::END_W-1:0] cfg_data,
    ors_req_if.sink                       req,
    ors_rsp_if.source                     rsp
);
    import ors_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_WR2, S_FINAL, S_RESP, S_LREAD, S_LOUT
    } state_t;

    state_t           state_reg, state_next;
    logic             act_reg, act_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [END_W-1:0] b_reg, b_next;
    logic [END_W-1:0] x_reg, x_next;
    logic             mark_reg, mark_next;
    logic             placed_reg, placed_next;
    logic [IDX_W-1:0] pend_b_reg, pend_b_next;
    logic [END_W-1:0] pend_e_reg, pend_e_next;
    logic [1:0]       st_reg, st_next;
    logic [END_W-1:0] cap_reg;

    logic             ov_reg, ov_next;
    logic [1:0]       os_reg, os_next;
    logic [IDX_W-1:0] ob_reg, ob_next;
    logic [END_W-1:0] oe_reg, oe_next;
    logic             orv_reg, orv_next;
    logic [CNT_W-1:0] ot_reg, ot_next;
    logic             ol_reg, ol_next;

    logic               wr_en;
    logic               wr_gated;
    logic [PTR_W:0]     wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [PTR_W:0]     rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [END_W-1:0]   sb, se;
    logic [END_W-1:0]   eff_cap, room, clip, req_end;
    logic               free, accept;
    logic [N_W-1:0]     n_fin;

    ors_ram #(.WIDTH(ENTRY_W), .DEPTH(2 * MAX_RANGES)) u_ram (
        .clk     (clk),
        .wr_en   (wr_gated),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr = {act_reg, i_reg[PTR_W-1:0]};
    assign sb      = {1'b0, rd_data[ENTRY_W-1:END_W]};
    assign se      = rd_data[END_W-1:0];
    assign free    = !ov_reg || rsp.ready;
    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign eff_cap = (cap_reg == '0) ? END_W'(1) :
                     (cap_reg > END_W'(INDEX_LIMIT)) ? END_W'(INDEX_LIMIT) : cap_reg;
    assign room    = eff_cap - {1'b0, req.start_index};
    assign clip    = (req.span_count < room) ? req.span_count : room;
    assign req_end = {1'b0, req.start_index} + clip;
    assign n_fin   = n_reg + N_W'(mark_reg && !placed_reg);

    assign rsp.valid       = ov_reg;
    assign rsp.status      = os_reg;
    assign rsp.range_begin = ob_reg;
    assign rsp.range_end   = oe_reg;
    assign rsp.range_valid = orv_reg;
    assign rsp.range_total = ot_reg;
    assign rsp.last        = ol_reg;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        b_next      = b_reg;
        x_next      = x_reg;
        mark_next   = mark_reg;
        placed_next = placed_reg;
        pend_b_next = pend_b_reg;
        pend_e_next = pend_e_reg;
        st_next     = st_reg;
        ov_next     = ov_reg && !rsp.ready;
        os_next     = os_reg;
        ob_next     = ob_reg;
        oe_next     = oe_reg;
        orv_next    = orv_reg;
        ot_next     = ot_reg;
        ol_next     = ol_reg;
        wr_en       = 1'b0;
        wr_data     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    i_next      = '0;
                    n_next      = '0;
                    placed_next = 1'b0;
                    st_next     = ST_DONE;
                    b_next      = {1'b0, req.start_index};
                    x_next      = req_end;
                    mark_next   = (req.req_type == REQ_MARK);
                    case (req.req_type)
                        REQ_LIST:
                            state_next = (cnt_reg == '0) ? S_RESP : S_LREAD;
                        REQ_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            if (req.span_count == '0 ||
                                {1'b0, req.start_index} >= eff_cap)
                            begin
                                st_next    = ST_IGNORED;
                                state_next = S_RESP;
                            end
                            else if (req.req_type == REQ_UNMARK && cnt_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = (cnt_reg == '0) ? S_FINAL : S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ:
                state_next = S_EVAL;
            S_EVAL:
            begin
                i_next     = i_reg + CNT_W'(1);
                state_next = (i_next == cnt_reg) ? S_FINAL : S_READ;
                if (mark_reg)
                begin
                    if (se < b_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {sb[IDX_W-1:0], se};
                    end
                    else if (sb > x_reg)
                    begin
                        wr_en = 1'b1;
                        if (!placed_reg)
                        begin
                            wr_data     = {b_reg[IDX_W-1:0], x_reg};
                            placed_next = 1'b1;
                            pend_b_next = sb[IDX_W-1:0];
                            pend_e_next = se;
                            state_next  = S_WR2;
                        end
                        else
                        begin
                            wr_data = {sb[IDX_W-1:0], se};
                        end
                    end
                    else
                    begin
                        if (sb < b_reg) b_next = sb;
                        if (se > x_reg) x_next = se;
                    end
                end
                else
                begin
                    if (se <= b_reg || sb >= x_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {sb[IDX_W-1:0], se};
                    end
                    else if (sb < b_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {sb[IDX_W-1:0], b_reg};
                        if (se > x_reg)
                        begin
                            // straddling range: right piece follows next cycle
                            pend_b_next = x_reg[IDX_W-1:0];
                            pend_e_next = se;
                            state_next  = S_WR2;
                        end
                    end
                    else if (se > x_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {x_reg[IDX_W-1:0], se};
                    end
                end
            end
            S_WR2:
            begin
                wr_en      = 1'b1;
                wr_data    = {pend_b_reg, pend_e_reg};
                state_next = (i_reg == cnt_reg) ? S_FINAL : S_READ;
            end
            S_FINAL:
            begin
                if (mark_reg && !placed_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = {b_reg[IDX_W-1:0], x_reg};
                end
                if (n_fin > N_W'(MAX_RANGES))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    act_next = !act_reg;
                    cnt_next = n_fin[CNT_W-1:0];
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (free)
                begin
                    ov_next    = 1'b1;
                    os_next    = st_reg;
                    ob_next    = '0;
                    oe_next    = '0;
                    orv_next   = 1'b0;
                    ot_next    = cnt_reg;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LREAD:
                state_next = S_LOUT;
            S_LOUT:
            begin
                if (free)
                begin
                    ov_next    = 1'b1;
                    os_next    = ST_DONE;
                    ob_next    = sb[IDX_W-1:0];
                    oe_next    = se;
                    orv_next   = 1'b1;
                    ot_next    = cnt_reg;
                    i_next     = i_reg + CNT_W'(1);
                    ol_next    = (i_next == cnt_reg);
                    state_next = ol_next ? S_IDLE : S_LREAD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (wr_en)
        begin
            n_next = n_reg + N_W'(1);
        end
    end

    // writes past the table depth are dropped; the count alone flags table full
    assign wr_addr  = {!act_reg, n_reg[PTR_W-1:0]};
    assign wr_gated = wr_en && (n_reg < N_W'(MAX_RANGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= 1'b0;
            cnt_reg    <= '0;
            cap_reg    <= END_W'(INDEX_LIMIT);
            ov_reg     <= 1'b0;
            i_reg      <= '0;
            n_reg      <= '0;
            b_reg      <= '0;
            x_reg      <= '0;
            mark_reg   <= 1'b0;
            placed_reg <= 1'b0;
            pend_b_reg <= '0;
            pend_e_reg <= '0;
            st_reg     <= ST_DONE;
            os_reg     <= ST_DONE;
            ob_reg     <= '0;
            oe_reg     <= '0;
            orv_reg    <= 1'b0;
            ot_reg     <= '0;
            ol_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            i_reg      <= i_next;
            n_reg      <= n_next;
            b_reg      <= b_next;
            x_reg      <= x_next;
            mark_reg   <= mark_next;
            placed_reg <= placed_next;
            pend_b_reg <= pend_b_next;
            pend_e_reg <= pend_e_next;
            st_reg     <= st_next;
            os_reg     <= os_next;
            ob_reg     <= ob_next;
            oe_reg     <= oe_next;
            orv_reg    <= orv_next;
            ot_reg     <= ot_next;
            ol_reg     <= ol_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ors_checker.sv =====
// Port-level assertions for the owned range set, bound to the top level.
`default_nettype none
module ors_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [1:0]                status,
    input wire logic [ors_pkg::IDX_W-1:0] range_begin,
    input wire logic [ors_pkg::END_W-1:0] range_end,
    input wire logic                      range_valid,
    input wire logic                      last
);
    import ors_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && range_valid |-> status == ST_DONE && {1'b0, range_begin} < range_end)
        else $error("listed range malformed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !range_valid |-> range_begin == '0 && range_end == '0 && last)
        else $error("non-range result carries range data");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == ST_DONE || status == ST_IGNORED || status == ST_FULL)
        else $error("bad status code");
endmodule

bind owned_range_set_top ors_checker u_ors_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .range_begin (rsp.range_begin),
    .range_end   (rsp.range_end),
    .range_valid (rsp.range_valid),
    .last        (rsp.last)
);
`default_nettype wire

// ===== dv/tb_owned_range_set_top.sv =====
// Self-checking testbench for the owned range set: directed and random requests.
module tb_owned_range_set_top;
    import ors_pkg::*;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] start;
        logic [END_W-1:0] span;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] rbegin;
        logic [END_W-1:0] rend;
        logic             rvalid;
        logic [CNT_W-1:0] total;
        logic             last;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [END_W-1:0] cfg_data;

    ors_req_if req ();
    ors_rsp_if rsp ();

    owned_range_set_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the range table
    int unsigned shadow_cap;
    int unsigned shadow_begin[$];
    int unsigned shadow_end[$];

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    int       failures;
    int       accepted_reqs;
    int       seen_outcomes;
    int       lists_done;
    int       full_seen;
    int       idle_cycles;
    bit       stim_done;

    function automatic int unsigned active_cap();
        if (shadow_cap == 0)
            return 1;
        if (shadow_cap > INDEX_LIMIT)
            return INDEX_LIMIT;
        return shadow_cap;
    endfunction

    function automatic outcome_t make_outcome(logic [1:0] st, int unsigned b,
                                              int unsigned e, bit v, int unsigned t,
                                              bit l);
        outcome_t o;
        o.status = st;
        o.rbegin = b[IDX_W-1:0];
        o.rend   = e[END_W-1:0];
        o.rvalid = v;
        o.total  = t[CNT_W-1:0];
        o.last   = l;
        return o;
    endfunction

    // Works out the results of one request and updates the shadow table.
    task automatic predict_request(request_t r);
        int unsigned cap;
        int unsigned s;
        int unsigned e;
        int unsigned nb[$];
        int unsigned ne[$];
        bit placed;
        logic [1:0] st;
        cap = active_cap();
        st = ST_DONE;
        if (r.kind == REQ_LIST)
        begin
            lists_done++;
            if (shadow_begin.size() == 0)
                expected_outcomes = {expected_outcomes,
                                     make_outcome(ST_DONE, 0, 0, 0, 0, 1)};
            for (int i = 0; i < shadow_begin.size(); i++)
                expected_outcomes = {expected_outcomes,
                                     make_outcome(ST_DONE, shadow_begin[i],
                                                  shadow_end[i], 1, shadow_begin.size(),
                                                  i == shadow_begin.size() - 1)};
            return;
        end
        if (r.kind == REQ_CLEAR)
        begin
            shadow_begin.delete();
            shadow_end.delete();
        end
        else if (r.span == 0 || r.start >= cap)
            st = ST_IGNORED;
        else
        begin
            s = r.start;
            e = s + ((r.span < cap - s) ? r.span : cap - s);
            placed = 0;
            for (int i = 0; i < shadow_begin.size(); i++)
            begin
                if (r.kind == REQ_MARK)
                begin
                    if (shadow_end[i] < s)
                    begin
                        nb = {nb, shadow_begin[i]};
                        ne = {ne, shadow_end[i]};
                    end
                    else if (shadow_begin[i] > e)
                    begin
                        if (!placed)
                        begin
                            nb = {nb, s};
                            ne = {ne, e};
                            placed = 1;
                        end
                        nb = {nb, shadow_begin[i]};
                        ne = {ne, shadow_end[i]};
                    end
                    else
                    begin
                        if (shadow_begin[i] < s)
                            s = shadow_begin[i];
                        if (shadow_end[i] > e)
                            e = shadow_end[i];
                    end
                end
                else if (shadow_end[i] <= s || shadow_begin[i] >= e)
                begin
                    nb = {nb, shadow_begin[i]};
                    ne = {ne, shadow_end[i]};
                end
                else
                begin
                    if (shadow_begin[i] < s)
                    begin
                        nb = {nb, shadow_begin[i]};
                        ne = {ne, s};
                    end
                    if (shadow_end[i] > e)
                    begin
                        nb = {nb, e};
                        ne = {ne, shadow_end[i]};
                    end
                end
            end
            if (r.kind == REQ_MARK && !placed)
            begin
                nb = {nb, s};
                ne = {ne, e};
            end
            if (nb.size() > MAX_RANGES)
            begin
                st = ST_FULL;
                full_seen++;
            end
            else
            begin
                shadow_begin = nb;
                shadow_end = ne;
            end
        end
        expected_outcomes = {expected_outcomes,
                             make_outcome(st, 0, 0, 0, shadow_begin.size(), 1)};
    endtask

    // Set at the posedge where the current item goes across
    bit req_taken;

    // Driver: bursts of transfers with random gaps
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (!(req.valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req.valid       <= 1'b1;
                req.req_type    <= pending_reqs[0].kind;
                req.start_index <= pending_reqs[0].start;
                req.span_count  <= pending_reqs[0].span;
                void'(pending_reqs.pop_front());
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        req_taken <= rst_n && req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
        begin
            predict_request('{req.req_type, req.start_index, req.span_count});
            accepted_reqs++;
        end
    end

    // Receiver stalls on a slowly changing pattern
    int stall_phase;
    always @(negedge clk)
    begin
        stall_phase = stall_phase + 1;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if ((stall_phase / 64) % 3 == 0)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            seen_outcomes++;
            if (expected_outcomes.size() == 0)
            begin
                $error("unexpected result, status %0d", rsp.status);
                failures++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    failures++;
                end
                if (rsp.range_begin !== want.rbegin)
                begin
                    $error("range_begin: expected %0d, got %0d", want.rbegin,
                           rsp.range_begin);
                    failures++;
                end
                if (rsp.range_end !== want.rend)
                begin
                    $error("range_end: expected %0d, got %0d", want.rend, rsp.range_end);
                    failures++;
                end
                if (rsp.range_valid !== want.rvalid)
                begin
                    $error("range_valid: expected %0d, got %0d", want.rvalid,
                           rsp.range_valid);
                    failures++;
                end
                if (rsp.range_total !== want.total)
                begin
                    $error("range_total: expected %0d, got %0d", want.total,
                           rsp.range_total);
                    failures++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp.last);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles == 5000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic request_t rand_request(int unsigned cap);
        request_t r;
        int unsigned p;
        r.kind = ($urandom_range(0, 9) < 6) ? REQ_MARK :
                 ($urandom_range(0, 2) != 0) ? REQ_UNMARK :
                 ($urandom_range(0, 3) == 0) ? REQ_CLEAR : REQ_LIST;
        p = $urandom_range(0, 19);
        if (p == 0)
            r.start = IDX_W'($urandom());
        else
            r.start = IDX_W'($urandom_range(0, (cap > 1) ? cap - 1 : 0));
        if (p == 1)
            r.span = END_W'($urandom());
        else if (p == 2)
            r.span = '0;
        else
            r.span = END_W'($urandom_range(1, 40));
        return r;
    endfunction

    task automatic queue_request(logic [1:0] k, int unsigned s, int unsigned n);
        pending_reqs = {pending_reqs, request_t'({k, s[IDX_W-1:0], n[END_W-1:0]})};
    endtask

    // Lets everything drain, then writes the capacity while the block is idle.
    task automatic set_capacity(int unsigned value);
        while (pending_reqs.size() > 0 || req.valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value[END_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        shadow_cap = value;
    endtask

    initial
    begin
        int unsigned caps[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.req_type = REQ_MARK;
        req.start_index = '0;
        req.span_count = '0;
        rsp.ready = 1'b0;
        shadow_cap = INDEX_LIMIT;
        caps = '{4096, 100, 8191, 0, 1, 4095};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, ignores, clipping, merge, split, full table
        queue_request(REQ_LIST, 0, 0);
        queue_request(REQ_UNMARK, 10, 5);
        queue_request(REQ_MARK, 5, 0);
        queue_request(REQ_MARK, 4095, 8191);
        queue_request(REQ_MARK, 0, 1);
        queue_request(REQ_MARK, 1, 3);
        queue_request(REQ_MARK, 10, 10);
        queue_request(REQ_MARK, 3, 8);
        queue_request(REQ_UNMARK, 6, 2);
        queue_request(REQ_LIST, 0, 0);
        queue_request(REQ_UNMARK, 0, 4096);
        for (int i = 0; i < 33; i++)
            queue_request(REQ_MARK, 2 * i, 1);
        queue_request(REQ_UNMARK, 0, 0);
        queue_request(REQ_UNMARK, 1, 0);
        queue_request(REQ_LIST, 0, 0);
        queue_request(REQ_CLEAR, 0, 0);
        set_capacity(100);
        queue_request(REQ_MARK, 100, 1);
        queue_request(REQ_MARK, 90, 4096);
        queue_request(REQ_LIST, 0, 0);

        for (int c = 0; c < 6; c++)
        begin
            set_capacity(caps[c]);
            for (int i = 0; i < 9; i++)
                pending_reqs = {pending_reqs, rand_request(active_cap())};
            queue_request(REQ_LIST, 0, 0);
            if ($urandom_range(0, 1))
                queue_request(REQ_CLEAR, 0, 0);
        end

        while (pending_reqs.size() > 0 || req.valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        $display("Covered %0d requests, %0d results, %0d lists, %0d full-table cases,",
                 accepted_reqs, seen_outcomes, lists_done, full_seen);
        $display("across capacities from zero up to the field maximum.");
        if (failures == 0 && expected_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
